// ===== rtl/pcomd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcomd_pkg: shared types and constants of the per-class dispatcher
// Queue geometry, action and status codes, and the structs that pass
// between the queue slots and the control logic.
// ----------------------------------------------------------------------------
package pcomd_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_WIDTH    = 32;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // request actions
   localparam logic [1:0] ACT_ENQUEUE  = 2'd0;
   localparam logic [1:0] ACT_MARK     = 2'd1;
   localparam logic [1:0] ACT_DISPATCH = 2'd2;

   // server numbers
   localparam logic [1:0] SRV_FIRST = 2'd0;
   localparam logic [1:0] SRV_LAST  = 2'd2;
   localparam logic [1:0] SRV_NONE  = 2'd3;

   typedef enum logic [2:0] {
      ST_QUEUED    = 3'd0,
      ST_FULL      = 3'd1,
      ST_MARKED    = 3'd2,
      ST_ALREADY   = 3'd3,
      ST_SERVED    = 3'd4,
      ST_NONE      = 3'd5,
      ST_NOT_READY = 3'd6
   } status_type;

   // one queue entry, as held in a slot and shifted between slots
   typedef struct packed {
      logic                valid;
      logic [1:0]          cls;
      logic [ID_WIDTH-1:0] id;
   } ent_type;

   // command broadcast to every slot
   typedef struct packed {
      logic                enq;
      logic                deq;
      logic [1:0]          cls;
      logic [ID_WIDTH-1:0] id;
   } cmd_type;

endpackage

// ===== rtl/pcomd_slot.sv =====
// ----------------------------------------------------------------------------
// pcomd_slot: one position of the arrival-ordered queue
// Holds one entry. Takes the new request when it is the first empty slot,
// and on a removal takes its upper neighbour's entry once the oldest match
// lies at or below it. Passes the match and taken id along the chain.
// ----------------------------------------------------------------------------
module pcomd_slot
   import pcomd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic                prev_valid,
   input  ent_type             nxt_ent,
   input  logic                found_in,
   input  logic [ID_WIDTH-1:0] taken_in,
   output ent_type             ent,
   output logic                found_out,
   output logic [ID_WIDTH-1:0] taken_out
);

   ent_type ent_ff;
   ent_type ent_in;
   logic    match;
   logic    first;

   // oldest-match search along the chain
   assign match     = ent_ff.valid & (ent_ff.cls == cmd.cls);
   assign first     = match & ~found_in;
   assign found_out = found_in | match;
   assign taken_out = taken_in | (first ? ent_ff.id : '0);
   assign ent       = ent_ff;

   // shift down on removal, fill at the tail on enqueue
   always_comb begin
      ent_in = ent_ff;
      if (cmd.deq && found_out) begin
         ent_in = nxt_ent;
      end else if (cmd.enq && !ent_ff.valid && prev_valid) begin
         ent_in.valid = 1'b1;
         ent_in.cls   = cmd.cls;
         ent_in.id    = cmd.id;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff.cls <= ent_in.cls;
      ent_ff.id  <= ent_in.id;
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
   end

endmodule

// ===== rtl/per_class_oldest_match_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// per_class_oldest_match_dispatcher_core: three-server oldest-first dispatcher
// A chain of queue slots holds waiting requests in arrival order; three
// servers with ready flags each take the oldest request of their class.
//
//   channel  | ports                       | handshake
//   ---------+-----------------------------+-----------------------------
//   request  | req_action, req_request_id, | taken when start & !busy
//            | req_request_class           |
//   result   | rsp_status .. rsp_last      | rsp_valid, one cycle each
//
// Enqueue and mark-ready give their result the cycle after the request,
// and the next request may follow at once. Dispatch serves one server per
// cycle through the slot chain, so busy stays high until the last server
// has been served, and it gives one result for each of the three servers.
// Synchronous reset empties the queue and clears all ready flags.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module per_class_oldest_match_dispatcher_core
   import pcomd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_action,
   input  logic [ID_WIDTH-1:0] req_request_id,
   input  logic [1:0]          req_request_class,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [1:0]          rsp_server_class,
   output logic [ID_WIDTH-1:0] rsp_served_id,
   output logic [2:0]          rsp_ready_flags,
   output logic [CNT_W-1:0]    rsp_queue_count,
   output logic                rsp_last
);

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_DISP = 2'b10
   } fsm_type;

   fsm_type             state_ff, state_in;
   logic [1:0]          srv_ff, srv_in;
   logic [2:0]          ready_ff, ready_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                vld_ff, vld_in;
   status_type          status_ff, status_in;
   logic [1:0]          cls_ff, cls_in;
   logic [ID_WIDTH-1:0] sid_ff, sid_in;
   logic                last_ff, last_in;

   logic                accept;
   logic                full;
   logic                disp_go;
   logic [1:0]          cur_srv;
   logic                srv_rdy;
   logic [2:0]          cls_mask;
   logic [2:0]          srv_mask;
   cmd_type             cmd;

   ent_type             ent_q   [QUEUE_DEPTH];
   logic                found_c [QUEUE_DEPTH+1];
   logic [ID_WIDTH-1:0] taken_c [QUEUE_DEPTH+1];

   assign busy    = (state_ff == FSM_DISP);
   assign accept  = start & ~busy;
   assign full    = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign disp_go = (accept && (req_action == ACT_DISPATCH)) || (state_ff == FSM_DISP);
   assign cur_srv = (state_ff == FSM_DISP) ? srv_ff : SRV_FIRST;
   assign srv_mask = 3'b001 << cur_srv;
   assign cls_mask = 3'b001 << req_request_class;
   assign srv_rdy  = |(ready_ff & srv_mask);

   // command to the slot chain
   always_comb begin
      cmd.enq = accept && (req_action == ACT_ENQUEUE) && !full;
      cmd.deq = disp_go && srv_rdy;
      cmd.cls = disp_go ? cur_srv : req_request_class;
      cmd.id  = req_request_id;
   end

   // queue slots, oldest at index zero
   assign found_c[0] = 1'b0;
   assign taken_c[0] = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      logic    prev_v;
      ent_type nxt_e;
      if (i == 0) begin : g_head
         assign prev_v = 1'b1;
      end else begin : g_body
         assign prev_v = ent_q[i-1].valid;
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign nxt_e = '0;
      end else begin : g_mid
         assign nxt_e = ent_q[i+1];
      end
      pcomd_slot u_slot (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_valid (prev_v),
         .nxt_ent    (nxt_e),
         .found_in   (found_c[i]),
         .taken_in   (taken_c[i]),
         .ent        (ent_q[i]),
         .found_out  (found_c[i+1]),
         .taken_out  (taken_c[i+1])
      );
   end

   // sequencer and result formation
   always_comb begin
      state_in  = state_ff;
      srv_in    = srv_ff;
      ready_in  = ready_ff;
      cnt_in    = cnt_ff;
      vld_in    = 1'b0;
      status_in = status_ff;
      cls_in    = cls_ff;
      sid_in    = '0;
      last_in   = 1'b1;

      if (accept) begin
         case (req_action)
            ACT_ENQUEUE: begin
               vld_in = 1'b1;
               cls_in = req_request_class;
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_QUEUED;
                  cnt_in    = cnt_ff + 1'b1;
               end
            end
            ACT_MARK: begin
               vld_in = 1'b1;
               cls_in = req_request_class;
               if (req_request_class == SRV_NONE) begin
                  status_in = ST_NOT_READY;
               end else if (|(ready_ff & cls_mask)) begin
                  status_in = ST_ALREADY;
               end else begin
                  status_in = ST_MARKED;
                  ready_in  = ready_ff | cls_mask;
               end
            end
            default: begin
            end
         endcase
      end

      // one server per cycle; the first in the request cycle itself
      if (disp_go) begin
         vld_in  = 1'b1;
         cls_in  = cur_srv;
         last_in = (cur_srv == SRV_LAST);
         if (!srv_rdy) begin
            status_in = ST_NOT_READY;
         end else if (found_c[QUEUE_DEPTH]) begin
            status_in = ST_SERVED;
            sid_in    = taken_c[QUEUE_DEPTH];
            ready_in  = ready_ff & ~srv_mask;
            cnt_in    = cnt_ff - 1'b1;
         end else begin
            status_in = ST_NONE;
         end
         if (cur_srv == SRV_LAST) begin
            state_in = FSM_IDLE;
         end else begin
            state_in = FSM_DISP;
            srv_in   = cur_srv + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      cls_ff    <= cls_in;
      sid_ff    <= sid_in;
      last_ff   <= last_in;
      if (reset) begin
         state_ff <= FSM_IDLE;
         srv_ff   <= SRV_FIRST;
         ready_ff <= '0;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         srv_ff   <= srv_in;
         ready_ff <= ready_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

   // flags and count are reported as they stand after the step
   assign rsp_valid        = vld_ff;
   assign rsp_status       = status_ff;
   assign rsp_server_class = cls_ff;
   assign rsp_served_id    = sid_ff;
   assign rsp_ready_flags  = ready_ff;
   assign rsp_queue_count  = cnt_ff;
   assign rsp_last         = last_ff;

endmodule
